@@ hw/rtl/sync_framed_packet_receiver_defines.svh @@
// ----------------------------------------------------------------------------
// Sync-framed packet receiver: assertion macros
// Shared concurrent assertion wrappers used by the receiver modules.
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAMED_PACKET_RECEIVER_DEFINES_SVH
`define SYNC_FRAMED_PACKET_RECEIVER_DEFINES_SVH

// Checked on every rising edge of clk outside reset.
`define SFPR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define SFPR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/sfpr_pkg.sv @@
// ----------------------------------------------------------------------------
// Sync-framed packet receiver package
// Parser states, result codes, register indexes and the result record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfpr_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 1'b1;

  localparam logic [7:0] SYNC_FIRST_RST  = 8'd181;
  localparam logic [7:0] SYNC_SECOND_RST = 8'd98;

  localparam logic [15:0] ERR_SAT = 16'hFFFF;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 72;

  // Parser phase, one-hot
  typedef enum logic [8:0] {
    PH_HUNT    = 9'b000000001,
    PH_SYNC1   = 9'b000000010,
    PH_CLASS   = 9'b000000100,
    PH_ID      = 9'b000001000,
    PH_LEN_LO  = 9'b000010000,
    PH_LEN_HI  = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_CHK_A   = 9'b010000000,
    PH_CHK_B   = 9'b100000000
  } phase_t;

  // Result codes
  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PAYLOAD = 3'd1,
    EV_GOOD    = 3'd2,
    EV_ZERO    = 3'd3,
    EV_LENGTH  = 3'd4,
    EV_CHECK   = 3'd5
  } ev_t;

  // One result item
  typedef struct packed {
    logic [15:0] errors_seen;
    logic [15:0] frame_length;
    logic [7:0]  frame_id;
    logic [7:0]  frame_class;
    logic [7:0]  byte_index;
    logic [7:0]  data_byte;
    ev_t         event_res;
  } result_t;

endpackage

@@ hw/rtl/sfpr_parser.sv @@
// ----------------------------------------------------------------------------
// Frame parser
// Per-item state update: sync hunt, header capture, Fletcher-8 check and
// the frame verdict. The result of each accepted item is formed here.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sync_framed_packet_receiver_defines.svh"

module sfpr_parser import sfpr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  item_fire,
  input  logic [7:0]            item_byte,
  output result_t               res
);

  localparam int unsigned CNT_W  = (MAX_PAYLOAD > 2) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [16:0] MAX_LEN = 17'(MAX_PAYLOAD);

  logic [7:0]       sync_first_r, sync_second_r;
  phase_t           phase_r, phase_nxt;
  logic [7:0]       class_r, class_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [15:0]      length_r, length_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       sum_a_r, sum_a_nxt;
  logic [7:0]       sum_b_r, sum_b_nxt;
  logic [15:0]      errors_r, errors_nxt;

  logic [7:0]  add_a, add_b;
  logic [15:0] len_full;
  logic [15:0] count_ext, count_inc;
  logic [15:0] errors_inc;
  ev_t         ev;
  logic [7:0]  data_out, index_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SYNC_FIRST_RST;
      sync_second_r <= SYNC_SECOND_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
        REG_SYNC_SECOND: sync_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Running Fletcher sums with the current byte folded in
  assign add_a      = sum_a_r + item_byte;
  assign add_b      = sum_b_r + add_a;
  assign len_full   = {item_byte, length_r[7:0]};
  assign count_ext  = 16'(count_r);
  assign count_inc  = count_ext + 16'd1;
  assign errors_inc = (errors_r == ERR_SAT) ? errors_r : errors_r + 16'd1;

  // Next state and result for the current item
  always_comb begin
    phase_nxt  = phase_r;
    class_nxt  = class_r;
    id_nxt     = id_r;
    length_nxt = length_r;
    count_nxt  = count_r;
    sum_a_nxt  = sum_a_r;
    sum_b_nxt  = sum_b_r;
    errors_nxt = errors_r;
    ev         = EV_NONE;
    data_out   = 8'd0;
    index_out  = 8'd0;

    unique case (phase_r)
      PH_SYNC1: begin
        if (item_byte == sync_second_r) begin
          phase_nxt = PH_CLASS;
          sum_a_nxt = 8'd0;
          sum_b_nxt = 8'd0;
        end else if (item_byte == sync_first_r) begin
          phase_nxt = PH_SYNC1;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_CLASS: begin
        class_nxt = item_byte;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = PH_ID;
      end
      PH_ID: begin
        id_nxt    = item_byte;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_nxt = {8'd0, item_byte};
        sum_a_nxt  = add_a;
        sum_b_nxt  = add_b;
        phase_nxt  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_nxt = len_full;
        sum_a_nxt  = add_a;
        sum_b_nxt  = add_b;
        count_nxt  = '0;
        // The announced length is checked once, here
        if ({1'b0, len_full} >= MAX_LEN) begin
          ev         = EV_LENGTH;
          errors_nxt = errors_inc;
          phase_nxt  = PH_HUNT;
        end else if (len_full == 16'd0) begin
          ev        = EV_ZERO;
          phase_nxt = PH_HUNT;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        ev        = EV_PAYLOAD;
        data_out  = item_byte;
        index_out = count_ext[7:0];
        count_nxt = count_inc[CNT_W-1:0];
        if (count_inc >= length_r) begin
          phase_nxt = PH_CHK_A;
        end
      end
      PH_CHK_A: begin
        if (item_byte == sum_a_r) begin
          phase_nxt = PH_CHK_B;
        end else begin
          ev        = EV_CHECK;
          phase_nxt = PH_HUNT;
        end
      end
      PH_CHK_B: begin
        // Of the two check bytes, only a second check byte mismatch is counted
        if (item_byte == sum_b_r) begin
          ev = EV_GOOD;
        end else begin
          ev         = EV_CHECK;
          errors_nxt = errors_inc;
        end
        phase_nxt = PH_HUNT;
      end
      default: begin
        phase_nxt = (item_byte == sync_first_r) ? PH_SYNC1 : PH_HUNT;
      end
    endcase
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      class_r  <= 8'd0;
      id_r     <= 8'd0;
      length_r <= 16'd0;
      count_r  <= '0;
      sum_a_r  <= 8'd0;
      sum_b_r  <= 8'd0;
      errors_r <= 16'd0;
    end else if (item_fire) begin
      phase_r  <= phase_nxt;
      class_r  <= class_nxt;
      id_r     <= id_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
      sum_a_r  <= sum_a_nxt;
      sum_b_r  <= sum_b_nxt;
      errors_r <= errors_nxt;
    end
  end

  // Result item, reflecting the state after this item
  always_comb begin
    res.event_res    = ev;
    res.data_byte    = data_out;
    res.byte_index   = index_out;
    res.frame_class  = class_nxt;
    res.frame_id     = id_nxt;
    res.frame_length = length_nxt;
    res.errors_seen  = errors_nxt;
  end

  `SFPR_ASSERT(a_payload_len_ok,
    (phase_r == PH_PAYLOAD) |-> ((length_r != 16'd0) && ({1'b0, length_r} < MAX_LEN)),
    "payload phase entered with an out-of-range length")
  `SFPR_ASSERT(a_payload_count_below_len,
    (phase_r == PH_PAYLOAD) |-> (count_ext < length_r),
    "payload count reached the length without leaving the payload phase")
  `SFPR_ASSERT(a_errors_monotonic,
    $past(rst_n) |-> (errors_r >= $past(errors_r)),
    "error count went backwards")
  `SFPR_ASSERT(a_payload_event_phase,
    (item_fire && (ev == EV_PAYLOAD)) |-> (phase_r == PH_PAYLOAD),
    "payload item reported outside the payload phase")

endmodule

@@ hw/rtl/sfpr_out_buf.sv @@
// ----------------------------------------------------------------------------
// Result output buffer
// Output register with one skid entry so the input side can take one more item
// after the output side stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sync_framed_packet_receiver_defines.svh"

module sfpr_out_buf import sfpr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_res,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    out_valid_r;
  result_t out_res_r;
  logic    skid_valid_r;
  result_t skid_res_r;
  logic    in_fire;
  logic    out_free;

  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = out_ready || !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || in_fire;
      skid_valid_r <= 1'b0;
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_res_r <= skid_res_r;
      end else if (in_fire) begin
        out_res_r <= in_res;
      end
    end else if (in_fire) begin
      skid_res_r <= in_res;
    end
  end

  `SFPR_ASSERT(a_skid_implies_out,
    skid_valid_r |-> out_valid_r,
    "skid entry held while the output register is empty")
  `SFPR_ASSERT(a_stall_keeps_out,
    (out_valid_r && !out_ready) |=> out_valid_r,
    "stalled result dropped from the output register")
  `SFPR_ASSERT(a_stall_fills_skid,
    (in_fire && out_valid_r && !out_ready) |=> skid_valid_r,
    "item taken during a stall was not parked in the skid entry")
  `SFPR_ASSERT_ALWAYS(a_reset_empty,
    !$past(rst_n) |-> (!out_valid_r && !skid_valid_r),
    "buffer not empty after reset")

endmodule

@@ hw/rtl/sync_framed_packet_receiver.sv @@
// Output: a result item is registered in the output register, or in the skid entry while the output stalls.
// Throughput: one item per cycle while in_tready is high; the per-byte parser update is combinational.
// Stalls: when out_tready is low, one more item is parked in a skid entry, then in_tready drops.
// Reset: rst_n is synchronous and active low; parser hunts for the first sync byte,
// sync bytes return to 181 and 98, counters, sums and header fields clear, buffers empty.
// ----------------------------------------------------------------------------
// Sync-framed packet receiver
// Parses sync-framed packets with a Fletcher-8 check, one received byte per
// item, reporting each payload byte and the verdict on each frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sync_framed_packet_receiver import sfpr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Configuration write port
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  // Input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] rx_byte
  // Result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [2:0] event_res, [10:3] data_byte, [18:11] byte_index, [26:19] frame_class,
  // [34:27] frame_id, [50:35] frame_length, [66:51] errors_seen, [71:67] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  result_t res_item;
  result_t res_out;
  logic    in_fire;

  assign in_fire = in_tvalid && in_tready;

  // Per-byte frame parser
  sfpr_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .item_fire (in_fire),
    .item_byte (in_tdata),
    .res       (res_item)
  );

  // Result register and skid entry
  sfpr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_res    (res_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res_out)
  );

  // Pack the result fields, event_res lowest
  assign out_tdata = {5'd0,
                      res_out.errors_seen,
                      res_out.frame_length,
                      res_out.frame_id,
                      res_out.frame_class,
                      res_out.byte_index,
                      res_out.data_byte,
                      res_out.event_res};

endmodule

@@ dv/sfpr_frame_checker.sv @@
// ----------------------------------------------------------------------------
// Sync-framed packet receiver: result checker
// Watches the configuration port and both streams, predicts each result item
// from its own copy of the parser state and compares it field by field with
// what the receiver produces.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfpr_frame_checker import sfpr_pkg::*; #(
  parameter int unsigned MAX_PAYLOAD = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  output int                     fail_count,
  output int                     pending,
  output int                     results_seen,
  output int                     good_frames,
  output int                     rejected_frames
);

  // Predicted parser state and sync-byte settings.
  phase_t      ph;
  logic [7:0]  sync_lead;
  logic [7:0]  sync_follow;
  logic [7:0]  cls_q;
  logic [7:0]  id_q;
  logic [15:0] len_q;
  logic [15:0] rcv_cnt;
  logic [7:0]  sum_a;
  logic [7:0]  sum_b;
  logic [15:0] err_total;

  result_t expected_results[$];
  int      mismatches = 0;
  int      n_results  = 0;
  int      n_good     = 0;
  int      n_rejected = 0;

  // Fletcher-8 running sums over class, id, length and payload.
  function automatic void accumulate(input logic [7:0] b);
    sum_a = sum_a + b;
    sum_b = sum_b + sum_a;
  endfunction

  // Advances the predicted parser by one received byte and returns its result.
  function automatic result_t parse_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    r.event_res = EV_NONE;
    case (ph)
      PH_SYNC1: begin
        if (b == sync_follow) begin
          ph    = PH_CLASS;
          sum_a = '0;
          sum_b = '0;
        end else if (b == sync_lead) begin
          ph = PH_SYNC1;
        end else begin
          ph = PH_HUNT;
        end
      end
      PH_CLASS: begin
        cls_q = b;
        accumulate(b);
        ph = PH_ID;
      end
      PH_ID: begin
        id_q = b;
        accumulate(b);
        ph = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_q = {8'h00, b};
        accumulate(b);
        ph = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_q = {b, len_q[7:0]};
        accumulate(b);
        rcv_cnt = '0;
        // The length is judged once, as soon as both bytes are in.
        if (32'(len_q) >= MAX_PAYLOAD) begin
          r.event_res = EV_LENGTH;
          if (err_total != ERR_SAT) err_total = err_total + 16'd1;
          ph = PH_HUNT;
        end else if (len_q == '0) begin
          r.event_res = EV_ZERO;
          ph = PH_HUNT;
        end else begin
          ph = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        accumulate(b);
        r.event_res  = EV_PAYLOAD;
        r.data_byte  = b;
        r.byte_index = rcv_cnt[7:0];
        rcv_cnt      = rcv_cnt + 16'd1;
        if (rcv_cnt >= len_q) ph = PH_CHK_A;
      end
      PH_CHK_A: begin
        if (b == sum_a) begin
          ph = PH_CHK_B;
        end else begin
          r.event_res = EV_CHECK;
          ph = PH_HUNT;
        end
      end
      PH_CHK_B: begin
        // Of the two check bytes, only a bad second one adds to the error count.
        if (b == sum_b) begin
          r.event_res = EV_GOOD;
        end else begin
          r.event_res = EV_CHECK;
          if (err_total != ERR_SAT) err_total = err_total + 16'd1;
        end
        ph = PH_HUNT;
      end
      default: begin
        ph = (b == sync_lead) ? PH_SYNC1 : PH_HUNT;
      end
    endcase
    r.frame_class  = cls_q;
    r.frame_id     = id_q;
    r.frame_length = len_q;
    r.errors_seen  = err_total;
    return r;
  endfunction

  task automatic compare(input string field, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("[%0t] %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endtask

  // The input item is folded in before the result item is taken, so that a
  // result can never overtake its own prediction.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      ph          = PH_HUNT;
      sync_lead   = SYNC_FIRST_RST;
      sync_follow = SYNC_SECOND_RST;
      cls_q       = '0;
      id_q        = '0;
      len_q       = '0;
      rcv_cnt     = '0;
      sum_a       = '0;
      sum_b       = '0;
      err_total   = '0;
      expected_results.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_SYNC_FIRST) sync_lead = cfg_wdata;
        else if (cfg_index == REG_SYNC_SECOND) sync_follow = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        expected_results.push_back(parse_byte(in_tdata[7:0]));
      end
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[$bits(result_t)-1:0]);
        n_results++;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("[%0t] result 0x%0h arrived with nothing expected: expected none, actual 0x%0h",
                   $time, out_tdata, out_tdata);
        end else begin
          want = expected_results.pop_front();
          compare("event_res", 16'(want.event_res), 16'(got.event_res));
          compare("data_byte", 16'(want.data_byte), 16'(got.data_byte));
          compare("byte_index", 16'(want.byte_index), 16'(got.byte_index));
          compare("frame_class", 16'(want.frame_class), 16'(got.frame_class));
          compare("frame_id", 16'(want.frame_id), 16'(got.frame_id));
          compare("frame_length", want.frame_length, got.frame_length);
          compare("errors_seen", want.errors_seen, got.errors_seen);
          compare("tdata padding", '0, 16'(out_tdata[OUT_TDATA_W-1:$bits(result_t)]));
          if (want.event_res == EV_GOOD) n_good++;
          else if (want.event_res != EV_NONE && want.event_res != EV_PAYLOAD) n_rejected++;
        end
      end
    end
    fail_count      <= mismatches;
    pending         <= expected_results.size();
    results_seen    <= n_results;
    good_frames     <= n_good;
    rejected_frames <= n_rejected;
  end

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// Sync-framed packet receiver testbench
// Feeds short directed byte sequences and then random frames, clean and
// damaged, under several sync-byte settings with random gaps and stalls on
// both streams. The checker beside the receiver predicts and compares every
// result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import sfpr_pkg::*;

  localparam int unsigned MAX_LEN      = 256;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned RANDOM_BYTES = 190;

  // Ways in which a generated frame may be damaged.
  typedef enum int {
    FRAME_CLEAN,
    FRAME_BAD_CK_A,
    FRAME_BAD_CK_B,
    FRAME_BAD_SYNC2,
    FRAME_CUT
  } frame_flaw_e;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic       calm   = 1'b0;
  logic [7:0] sync_a = SYNC_FIRST_RST;
  logic [7:0] sync_b = SYNC_SECOND_RST;
  int         bytes_sent  = 0;
  int         sink_hold   = 0;
  int         idle_cycles = 0;

  int fail_count;
  int pending;
  int results_seen;
  int good_frames;
  int rejected_frames;

  sync_framed_packet_receiver #(
    .MAX_PAYLOAD (MAX_LEN)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  sfpr_frame_checker #(
    .MAX_PAYLOAD (MAX_LEN)
  ) frame_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_seen    (results_seen),
    .good_frames     (good_frames),
    .rejected_frames (rejected_frames)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Result side: after each accepted item, tready is held low while a random hold count, zero when calm, runs down.
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_hold = 0;
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) sink_hold = calm ? 0 : $urandom_range(0, 3);
      else if (sink_hold > 0) sink_hold = sink_hold - 1;
      out_tready <= (sink_hold == 0);
    end
  end

  // Watchdog: too long without any item moving on either stream ends the run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offers one byte after a random gap and returns at the edge that takes it.
  // Valid stays high when the next byte follows without a gap.
  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (in_tready !== 1'b1);
    bytes_sent++;
  endtask

  // Sends a byte that is covered by the frame check and folds it into the sums.
  task automatic push_summed(input logic [7:0] b, inout logic [7:0] ca, inout logic [7:0] cb);
    push_byte(b);
    ca = ca + b;
    cb = cb + ca;
  endtask

  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [15:0] len, input frame_flaw_e flaw);
    logic [7:0] ca;
    logic [7:0] cb;
    int         k;
    ca = '0;
    cb = '0;
    push_byte(sync_a);
    if (flaw == FRAME_BAD_SYNC2) begin
      push_byte(sync_b ^ 8'($urandom_range(1, 255)));
      return;
    end
    push_byte(sync_b);
    push_summed(cls, ca, cb);
    push_summed(id, ca, cb);
    push_summed(len[7:0], ca, cb);
    push_summed(len[15:8], ca, cb);
    if (len == 16'd0 || len >= MAX_LEN) return;
    for (k = 0; k < len; k++) begin
      // A cut frame stops halfway; the next frame's bytes then land in its payload.
      if (flaw == FRAME_CUT && k == len / 2) return;
      push_summed(8'($urandom), ca, cb);
    end
    if (flaw == FRAME_BAD_CK_A) begin
      push_byte(ca ^ 8'($urandom_range(1, 255)));
      return;
    end
    push_byte(ca);
    push_byte((flaw == FRAME_BAD_CK_B) ? (cb ^ 8'($urandom_range(1, 255))) : cb);
  endtask

  // Mostly short well-formed frames, some long, zero-length or oversized, a
  // share damaged, with occasional line noise in between.
  task automatic random_frame();
    int          pick;
    logic [15:0] len;
    frame_flaw_e flaw;
    calm <= ($urandom_range(0, 7) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 6) len = 16'd0;
    else if (pick < 8) len = 16'(MAX_LEN);
    else if (pick < 9) len = 16'hFFFF;
    else if (pick < 12) len = 16'($urandom_range(MAX_LEN, 65535));
    else if (pick < 16) len = 16'($urandom_range(MAX_LEN - 56, MAX_LEN - 1));
    else len = 16'($urandom_range(1, 12));
    pick = $urandom_range(0, 99);
    flaw = (pick < 68) ? FRAME_CLEAN :
           (pick < 77) ? FRAME_BAD_CK_A :
           (pick < 86) ? FRAME_BAD_CK_B :
           (pick < 93) ? FRAME_BAD_SYNC2 : FRAME_CUT;
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
    end
    send_frame(8'($urandom), 8'($urandom), len, flaw);
  endtask

  task automatic run_random(input int target);
    while (bytes_sent < target) random_frame();
  endtask

  // Stops offering bytes and waits until every result item has come out.
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_sync(input logic [7:0] lead, input logic [7:0] follow);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_SYNC_FIRST;
    cfg_wdata <= lead;
    @(posedge clk);
    cfg_index <= REG_SYNC_SECOND;
    cfg_wdata <= follow;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sync_a = lead;
    sync_b = follow;
  endtask

  task automatic new_phase(input logic [7:0] lead, input logic [7:0] follow);
    settle();
    set_sync(lead, follow);
    run_random(bytes_sent + RANDOM_BYTES);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Wrong second sync byte, then one that repeats the first sync byte.
    push_byte(8'h00);
    push_byte(sync_a);
    push_byte(8'h00);
    push_byte(sync_a);
    send_frame(8'hFF, 8'h00, 16'd0, FRAME_CLEAN);
    // Largest length, then the shortest good frame.
    send_frame(8'h00, 8'hFF, 16'hFFFF, FRAME_CLEAN);
    send_frame(8'hFF, 8'h00, 16'd1, FRAME_CLEAN);
    run_random(bytes_sent + RANDOM_BYTES);

    new_phase(8'h00, 8'hFF);
    new_phase(8'hFF, 8'h00);
    // Both sync bytes equal.
    new_phase(8'h5A, 8'h5A);
    new_phase(8'($urandom), 8'($urandom));

    // Back to the reset sync bytes for a last stretch of mixed traffic.
    settle();
    set_sync(SYNC_FIRST_RST, SYNC_SECOND_RST);
    run_random(bytes_sent + 120);
    settle();
    repeat (5) @(posedge clk);

    $display("Covered: %0d bytes under six sync-byte settings, %0d result items checked.",
             bytes_sent, results_seen);
    $display("Covered: %0d good frames and %0d rejected frames.",
             good_frames, rejected_frames);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
